// ===== design/dirt_pkg.sv =====
`default_nettype none
package dirt_pkg;
	// opcodes
	localparam logic [1:0] OP_STORE  = 2'd0;
	localparam logic [1:0] OP_INTERP = 2'd1;
	localparam logic [1:0] OP_SINGLE = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;
	// result status codes
	localparam logic [1:0] ST_INTERP = 2'd0;
	localparam logic [1:0] ST_SINGLE = 2'd1;
	localparam logic [1:0] ST_NOEARLY = 2'd2;
	// register indexes
	localparam logic [2:0] REG_ROT0 = 3'd0;
	localparam logic [2:0] REG_ROT1 = 3'd1;
	localparam logic [2:0] REG_ROT2 = 3'd2;
	localparam logic [2:0] REG_SHX  = 3'd3;
	localparam logic [2:0] REG_SHY  = 3'd4;
	localparam logic [2:0] REG_SHZ  = 3'd5;
	localparam logic [2:0] REG_CAL  = 3'd6;
	localparam int CFG_DATA_W = 48;
	localparam int CONF_W = 16;
	localparam int COEF_W = 16;
	localparam int ROT_FRAC = 14;

	// controller to datapath commands
	typedef struct packed {
		logic load;       // capture input word
		logic store;      // write earlier sample
		logic div_start;  // start alpha divider
		logic blend_en;   // blend one lane
		logic rot_clr;    // preset accumulator to the rounding half
		logic rot_mac;    // one coefficient product
		logic rot_done;   // write one global lane
		logic copy;       // uncalibrated copy
		logic out_load;   // move result to output register
		logic [2:0] lane;
		logic [1:0] col;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic div_busy;
		logic calibrated;
		logic early_valid;
		logic [1:0] op;
	} sts_t;
endpackage
`default_nettype wire

// ===== design/dirt_ctrl.sv =====
`default_nettype none
module dirt_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	input  wire dirt_pkg::sts_t sts,
	output dirt_pkg::ctl_t ctl
);
	import dirt_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_BLEND = 3'd2;
	localparam logic [2:0] S_ROT   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;
	localparam logic [2:0] S_DEC   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] lane_q;
	logic [1:0] col_q;
	logic       ovalid_q;
	logic       busy_q;

	// accept when no item is in work; result register may still be full
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovalid_q;

	always_comb begin
		ctl = '0;
		ctl.lane = lane_q;
		ctl.col = col_q;
		ctl.load = in_valid && in_ready;
		case (state_q)
			S_DEC: begin
				if (sts.op == OP_STORE) ctl.store = 1'b1;
				if (sts.op == OP_INTERP && sts.early_valid) ctl.div_start = 1'b1;
				ctl.rot_clr = 1'b1;
			end
			S_BLEND: ctl.blend_en = 1'b1;
			S_ROT: begin
				if (sts.calibrated) begin
					ctl.rot_mac = 1'b1;
					ctl.rot_done = (col_q == 2'd3);
					ctl.rot_clr = (col_q == 2'd3);
				end else begin
					ctl.copy = 1'b1;
				end
			end
			S_FIN: ctl.out_load = !ovalid_q || out_ready;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lane_q <= '0;
			col_q <= '0;
			ovalid_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DEC;
				S_DEC: begin
					lane_q <= '0;
					col_q <= '0;
					if (sts.op == OP_STORE || sts.op == OP_NONE) state_q <= S_IDLE;
					else if (sts.op == OP_INTERP && !sts.early_valid) state_q <= S_FIN;
					else if (sts.op == OP_INTERP) state_q <= S_DIV;
					else state_q <= S_ROT;
					busy_q <= (sts.op == OP_INTERP);
				end
				S_DIV: if (!sts.div_busy && !busy_q) state_q <= S_BLEND;
					else busy_q <= 1'b0;
				S_BLEND: begin
					if (lane_q == 3'd7) begin
						lane_q <= '0;
						state_q <= S_ROT;
					end else lane_q <= lane_q + 3'd1;
				end
				S_ROT: begin
					if (!sts.calibrated || col_q == 2'd3) begin
						col_q <= '0;
						if (!sts.calibrated || lane_q == 3'd5) state_q <= S_FIN;
						else lane_q <= lane_q + 3'd1;
					end else col_q <= col_q + 2'd1;
				end
				S_FIN: if (!ovalid_q || out_ready) begin
					ovalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/dirt_dp.sv =====
`default_nettype none
module dirt_dp #(
	parameter int COORD_WIDTH = 32,
	parameter int TIME_WIDTH = 48,
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire dirt_pkg::ctl_t ctl,
	output dirt_pkg::sts_t sts,
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [dirt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [1:0] opcode,
	input  wire logic [TIME_WIDTH-1:0] sample_time,
	input  wire logic [TIME_WIDTH-1:0] sync_time,
	input  wire logic signed [COORD_WIDTH-1:0] pos_x, pos_y, pos_z,
	input  wire logic signed [COORD_WIDTH-1:0] vel_x, vel_y, vel_z,
	input  wire logic [dirt_pkg::CONF_W-1:0] class_conf, detect_conf,
	output logic [1:0] status,
	output logic [TIME_WIDTH-1:0] out_time,
	output logic signed [COORD_WIDTH-1:0] gpos_x, gpos_y, gpos_z,
	output logic signed [COORD_WIDTH-1:0] gvel_x, gvel_y, gvel_z,
	output logic [dirt_pkg::CONF_W-1:0] out_class_conf, out_detect_conf
);
	import dirt_pkg::*;

	localparam int F = ALPHA_FRAC_BITS;
	localparam int CW = COORD_WIDTH;
	localparam int TW = TIME_WIDTH;
	localparam int DW = CW + 1;          // difference width
	localparam int BW = DW + F + 2;      // blend product width
	localparam int PW = CW + COEF_W;     // rotation product
	localparam int AW = PW + 3;          // accumulator
	localparam int CNTW = $clog2(F + 1);

	// configuration registers
	logic [3*COEF_W-1:0] rot_q [3];
	logic signed [CW-1:0] shift_q [3];
	logic cal_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= 48'h0000_0000_4000;
			rot_q[1] <= 48'h0000_4000_0000;
			rot_q[2] <= 48'h4000_0000_0000;
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
			cal_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROT0: rot_q[0] <= cfg_data;
				REG_ROT1: rot_q[1] <= cfg_data;
				REG_ROT2: rot_q[2] <= cfg_data;
				REG_SHX: shift_q[0] <= CW'($signed(cfg_data[31:0]));
				REG_SHY: shift_q[1] <= CW'($signed(cfg_data[31:0]));
				REG_SHZ: shift_q[2] <= CW'($signed(cfg_data[31:0]));
				REG_CAL: cal_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input word register
	logic [1:0] op_q;
	logic [TW-1:0] ts_q, tt_q;
	logic signed [CW-1:0] v_q [8];   // six coordinates, two confidences
	logic signed [CW-1:0] bl_res;
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q <= opcode;
			ts_q <= sample_time;
			tt_q <= sync_time;
			v_q[0] <= pos_x; v_q[1] <= pos_y; v_q[2] <= pos_z;
			v_q[3] <= vel_x; v_q[4] <= vel_y; v_q[5] <= vel_z;
			v_q[6] <= CW'(class_conf);
			v_q[7] <= CW'(detect_conf);
		end else if (ctl.blend_en) begin
			v_q[ctl.lane] <= bl_res;
		end else if (ctl.rot_done || ctl.copy) begin
			; // lanes held until result built
		end
	end

	// earlier sample store
	logic early_valid_q;
	logic [TW-1:0] et_q;
	logic signed [CW-1:0] ev_q [8];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) early_valid_q <= 1'b0;
		else if (ctl.store) early_valid_q <= 1'b1;
	end
	always_ff @(posedge clk) begin
		if (ctl.store) begin
			et_q <= ts_q;
			for (int i = 0; i < 8; i++) ev_q[i] <= v_q[i];
		end
	end

	// alpha: restoring divider, one bit a cycle
	logic [TW-1:0] num_c, den_c;
	logic nneg, dneg;
	assign nneg = tt_q < et_q;
	assign dneg = ts_q < et_q;
	assign num_c = nneg ? et_q - tt_q : tt_q - et_q;
	assign den_c = dneg ? et_q - ts_q : ts_q - et_q;
	logic [TW:0] rem_q;
	logic [TW-1:0] den_q;
	logic [F:0] alpha_q;
	logic [CNTW-1:0] cnt_q;
	logic div_busy_q;
	logic [TW+1:0] rsh;
	assign rsh = {rem_q, 1'b0};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.div_start) begin
			rem_q <= {1'b0, num_c};
			den_q <= den_c;
			cnt_q <= '0;
			if (den_c == '0 || num_c == '0 || nneg != dneg) begin
				alpha_q <= '0;
				div_busy_q <= 1'b0;
			end else if (num_c >= den_c) begin
				alpha_q <= (F+1)'(1) << F;
				div_busy_q <= 1'b0;
			end else begin
				alpha_q <= '0;
				div_busy_q <= 1'b1;
			end
		end else if (div_busy_q) begin
			if (rsh >= {2'b00, den_q}) begin
				rem_q <= (TW+1)'(rsh - {2'b00, den_q});
				alpha_q <= {alpha_q[F-1:0], 1'b1};
			end else begin
				rem_q <= rsh[TW:0];
				alpha_q <= {alpha_q[F-1:0], 1'b0};
			end
			cnt_q <= cnt_q + CNTW'(1);
			if (cnt_q == CNTW'(F - 1)) div_busy_q <= 1'b0;
		end
	end

	// blend of one lane: e + round(d * alpha)
	logic signed [DW-1:0] bl_d;
	logic signed [BW-1:0] bl_p;
	assign bl_d = DW'(v_q[ctl.lane]) - DW'(ev_q[ctl.lane]);
	assign bl_p = (BW'(bl_d) * $signed({1'b0, alpha_q})
		+ (BW'(1) <<< (F - 1))) >>> F;
	assign bl_res = CW'(BW'(ev_q[ctl.lane]) + bl_p);

	// rotation: one coefficient product a cycle into an accumulator
	logic [1:0] row;
	logic [2:0] vbase;
	assign row = (ctl.lane >= 3'd3) ? 2'(ctl.lane - 3'd3) : ctl.lane[1:0];
	assign vbase = (ctl.lane >= 3'd3) ? 3'd3 : 3'd0;
	logic signed [COEF_W-1:0] coef;
	logic signed [PW-1:0] prod;
	logic signed [AW-1:0] acc_q;
	logic [1:0] colc;
	assign colc = (ctl.col == 2'd3) ? 2'd2 : ctl.col;
	assign coef = $signed(rot_q[row][colc*COEF_W +: COEF_W]);
	assign prod = PW'(coef) * PW'(v_q[vbase + 3'(colc)]);
	always_ff @(posedge clk) begin
		if (ctl.rot_clr) acc_q <= AW'(1) <<< (ROT_FRAC - 1);
		else if (ctl.rot_mac) acc_q <= acc_q + AW'(prod);
	end

	// saturate and write lane
	localparam logic signed [AW-1:0] HI = AW'({1'b0, {(CW-1){1'b1}}});
	localparam logic signed [AW-1:0] LO = -HI - AW'(1);
	logic signed [AW-1:0] rsum;
	logic signed [CW-1:0] rsat;
	assign rsum = (acc_q >>> ROT_FRAC)
		+ ((ctl.lane < 3'd3) ? AW'(shift_q[row]) : AW'(0));
	assign rsat = (rsum > HI) ? CW'(HI) : (rsum < LO) ? CW'(LO) : CW'(rsum);

	logic signed [CW-1:0] g_q [6];
	always_ff @(posedge clk) begin
		if (ctl.rot_done) g_q[ctl.lane] <= rsat;
		else if (ctl.copy)
			for (int i = 0; i < 6; i++) g_q[i] <= v_q[i];
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			if (op_q == OP_INTERP && !early_valid_q) begin
				status <= ST_NOEARLY;
				out_time <= ts_q;
				{gpos_x, gpos_y, gpos_z, gvel_x, gvel_y, gvel_z} <= '0;
				out_class_conf <= '0;
				out_detect_conf <= '0;
			end else begin
				status <= (op_q == OP_INTERP) ? ST_INTERP : ST_SINGLE;
				out_time <= (op_q == OP_INTERP) ? tt_q : ts_q;
				gpos_x <= g_q[0]; gpos_y <= g_q[1]; gpos_z <= g_q[2];
				gvel_x <= g_q[3]; gvel_y <= g_q[4]; gvel_z <= g_q[5];
				out_class_conf <= v_q[6][CONF_W-1:0];
				out_detect_conf <= v_q[7][CONF_W-1:0];
			end
		end
	end

	assign sts.div_busy = div_busy_q;
	assign sts.calibrated = cal_q;
	assign sts.early_valid = early_valid_q;
	assign sts.op = op_q;
endmodule
`default_nettype wire

// ===== design/detection_interp_rigid_transform_top.sv =====
// Detection interpolation with rigid transform.
// Input channel in_valid/in_ready carries one sample word: opcode, times,
// local position, velocity and confidences. Output channel out_valid/
// out_ready carries one result word for interpolate and pass-through
// opcodes; a store opcode gives no result.
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// Work per accepted word: a store goes back to idle from the decode step;
// pass-through copies the lanes uncalibrated, or calibrated works six rows
// of four steps (three products and a write) through one multiplier;
// interpolate adds the alpha divider and a blend of each of the eight
// lanes ahead of that.
// One item is in work at a time; the next word can be taken in the cycle
// after the result register loads, and the rate is set by the alpha
// divider and the shared rotation multiplier.
// Reset clears the sequencer, the earlier-sample valid flag and loads
// the identity matrix, zero shift and calibration off.
// A stalled receiver holds the result register; a new word is still
// taken and worked on, and waits in the last step until the register frees.
`default_nettype none
module detection_interp_rigid_transform_top #(
	parameter int COORD_WIDTH = 32,
	parameter int TIME_WIDTH = 48,
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [1:0] opcode,
	input  wire logic [TIME_WIDTH-1:0] sample_time,
	input  wire logic [TIME_WIDTH-1:0] sync_time,
	input  wire logic signed [COORD_WIDTH-1:0] pos_x, pos_y, pos_z,
	input  wire logic signed [COORD_WIDTH-1:0] vel_x, vel_y, vel_z,
	input  wire logic [dirt_pkg::CONF_W-1:0] class_conf, detect_conf,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [1:0] status,
	output logic [TIME_WIDTH-1:0] out_time,
	output logic signed [COORD_WIDTH-1:0] gpos_x, gpos_y, gpos_z,
	output logic signed [COORD_WIDTH-1:0] gvel_x, gvel_y, gvel_z,
	output logic [dirt_pkg::CONF_W-1:0] out_class_conf, out_detect_conf,
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [dirt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dirt_pkg::*;

	ctl_t ctl;
	sts_t sts;

	dirt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.sts, .ctl
	);

	dirt_dp #(
		.COORD_WIDTH(COORD_WIDTH), .TIME_WIDTH(TIME_WIDTH),
		.ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)
	) u_dp (
		.clk, .arst_n, .ctl, .sts, .cfg_we, .cfg_index, .cfg_data,
		.opcode, .sample_time, .sync_time,
		.pos_x, .pos_y, .pos_z, .vel_x, .vel_y, .vel_z,
		.class_conf, .detect_conf,
		.status, .out_time, .gpos_x, .gpos_y, .gpos_z,
		.gvel_x, .gvel_y, .gvel_z, .out_class_conf, .out_detect_conf
	);
endmodule
`default_nettype wire

// ===== design/dirt_chk.sv =====
`default_nettype none
module dirt_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [1:0] status
);
	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result word dropped while stalled");
	// one word in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while one in work");
	// status code is a defined one
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("bad status");
endmodule

bind detection_interp_rigid_transform_top dirt_chk u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .status
);
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import dirt_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 100;

	typedef struct packed {
		logic [1:0] op;
		logic [47:0] ts;
		logic [47:0] tt;
		logic [5:0][31:0] v;
		logic [15:0] cc;
		logic [15:0] dc;
	} sample_t;

	typedef struct packed {
		logic [1:0] st;
		logic [47:0] tm;
		logic [5:0][31:0] g;
		logic [15:0] cc;
		logic [15:0] dc;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = OP_NONE;
	logic [47:0] sample_time = '0, sync_time = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
	logic [15:0] class_conf = '0, detect_conf = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [47:0] out_time;
	logic signed [31:0] gpos_x, gpos_y, gpos_z, gvel_x, gvel_y, gvel_z;
	logic [15:0] out_class_conf, out_detect_conf;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_ROT0;
	logic [47:0] cfg_data = '0;

	detection_interp_rigid_transform_top DUT (.*);

	always #5 clk = ~clk;

	// pending words, expected results and bookkeeping
	sample_t sample_q[$];
	result_t result_q[$];
	int errors = 0;
	int results_seen = 0;
	int cycles = 0;
	bit quiet = 1'b0;
	bit word_taken = 1'b0;

	// append one word to the pending queue
	function automatic void add_word(sample_t s);
		sample_q.insert(sample_q.size(), s);
	endfunction

	// predictor copy of registers and earlier sample
	logic [47:0] rot_m[3];
	logic signed [31:0] shift_m[3];
	bit cal_m;
	bit early_ok;
	logic [47:0] early_ts;
	logic [5:0][31:0] early_v;
	logic [15:0] early_cc, early_dc;

	function automatic logic [16:0] alpha_of(logic [47:0] te, logic [47:0] tl, logic [47:0] tt);
		bit nneg, dneg;
		logic [63:0] num, den;
		nneg = tt < te;
		dneg = tl < te;
		num = nneg ? te - tt : tt - te;
		den = dneg ? te - tl : tl - te;
		if (den == 0 || num == 0 || nneg != dneg)
			return '0;
		if (num >= den)
			return 17'h10000;
		return 17'((num << 16) / den);
	endfunction

	function automatic logic signed [127:0] mix(logic signed [127:0] e, logic signed [127:0] l,
			logic [16:0] a);
		logic signed [127:0] d, aw;
		d = l - e;
		aw = {111'b0, a};
		return e + ((d * aw + 128'sd32768) >>> 16);
	endfunction

	function automatic logic signed [127:0] rot_lane(logic [1:0] row, logic signed [127:0] a,
			logic signed [127:0] b, logic signed [127:0] c);
		logic signed [127:0] k0, k1, k2;
		k0 = $signed(rot_m[row][15:0]);
		k1 = $signed(rot_m[row][31:16]);
		k2 = $signed(rot_m[row][47:32]);
		return (k0 * a + k1 * b + k2 * c + 128'sd8192) >>> 14;
	endfunction

	function automatic logic [31:0] clip32(logic signed [127:0] x);
		if (x > 128'sd2147483647)
			return 32'h7fffffff;
		if (x < -128'sd2147483648)
			return 32'h80000000;
		return x[31:0];
	endfunction

	// work out the result of one accepted word; returns 0 when none is due
	function automatic bit predict_result(sample_t s, output result_t r);
		logic signed [127:0] w[6];
		logic [16:0] a;
		r = '0;
		if (s.op == OP_NONE)
			return 1'b0;
		if (s.op == OP_STORE) begin
			early_ok = 1'b1;
			early_ts = s.ts;
			early_v = s.v;
			early_cc = s.cc;
			early_dc = s.dc;
			return 1'b0;
		end
		for (int i = 0; i < 6; i++)
			w[i] = $signed(s.v[i]);
		r.cc = s.cc;
		r.dc = s.dc;
		if (s.op == OP_INTERP) begin
			if (!early_ok) begin
				r.st = ST_NOEARLY;
				r.tm = s.ts;
				r.cc = '0;
				r.dc = '0;
				return 1'b1;
			end
			a = alpha_of(early_ts, s.ts, s.tt);
			for (int i = 0; i < 6; i++)
				w[i] = mix($signed(early_v[i]), w[i], a);
			r.cc = 16'(mix({112'b0, early_cc}, {112'b0, s.cc}, a));
			r.dc = 16'(mix({112'b0, early_dc}, {112'b0, s.dc}, a));
			r.st = ST_INTERP;
			r.tm = s.tt;
		end else begin
			r.st = ST_SINGLE;
			r.tm = s.ts;
		end
		for (int i = 0; i < 3; i++) begin
			if (cal_m) begin
				r.g[i] = clip32(rot_lane(2'(i), w[0], w[1], w[2]) + shift_m[i]);
				r.g[3+i] = clip32(rot_lane(2'(i), w[3], w[4], w[5]));
			end else begin
				r.g[i] = w[i][31:0];
				r.g[3+i] = w[3+i][31:0];
			end
		end
		return 1'b1;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	// input and output sampling at the rising edge
	always @(posedge clk) begin
		sample_t s;
		result_t r, e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			word_taken = in_valid && in_ready;
			if (word_taken) begin
				s.op = opcode;
				s.ts = sample_time;
				s.tt = sync_time;
				s.v = {vel_z, vel_y, vel_x, pos_z, pos_y, pos_x};
				s.cc = class_conf;
				s.dc = detect_conf;
				if (predict_result(s, r))
					result_q.insert(result_q.size(), r);
			end
			if (out_valid && out_ready) begin
				results_seen++;
				r.st = status;
				r.tm = out_time;
				r.g = {gvel_z, gvel_y, gvel_x, gpos_z, gpos_y, gpos_x};
				r.cc = out_class_conf;
				r.dc = out_detect_conf;
				if (result_q.size() == 0) begin
					report("unexpected word, status", r.st, 0);
				end else begin
					e = result_q.pop_front();
					if (r.st != e.st) report("status", r.st, e.st);
					if (r.tm != e.tm) report("out_time", r.tm, e.tm);
					for (int i = 0; i < 6; i++)
						if (r.g[i] != e.g[i]) report($sformatf("global lane %0d", i), r.g[i], e.g[i]);
					if (r.cc != e.cc) report("out_class_conf", r.cc, e.cc);
					if (r.dc != e.dc) report("out_detect_conf", r.dc, e.dc);
				end
			end
		end
	end

	function automatic int pause_len();
		int p;
		if (quiet)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// sender: one word at a time from the pending queue
	int send_gap = 0;
	always @(negedge clk) begin
		sample_t s;
		if (arst_n && (!in_valid || word_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				s = sample_q.pop_front();
				opcode <= s.op;
				sample_time <= s.ts;
				sync_time <= s.tt;
				{vel_z, vel_y, vel_x, pos_z, pos_y, pos_x} <= s.v;
				class_conf <= s.cc;
				detect_conf <= s.dc;
				in_valid <= 1'b1;
				send_gap = pause_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	int hold_left = 0;
	bit long_hold_done = 1'b0;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!long_hold_done && results_seen >= 150) begin
			long_hold_done = 1'b1;
			hold_left = 500;
			out_ready <= 1'b0;
		end else if (pause_len() == 0) begin
			out_ready <= 1'b1;
		end else begin
			hold_left = pause_len();
			out_ready <= 1'b0;
		end
	end

	function automatic logic [47:0] rand_time();
		int p;
		p = $urandom_range(0, 3);
		if (p == 0) return 48'({$urandom, $urandom});
		if (p == 1) return 48'($urandom_range(0, 100000));
		if (p == 2) return 48'hffff_ffff_0000 + 48'($urandom);
		return {16'($urandom), $urandom};
	endfunction

	function automatic logic [31:0] rand_coord();
		int p;
		p = $urandom_range(0, 9);
		if (p < 5) return $urandom;
		if (p < 8) return 32'($signed($urandom_range(0, 2000000)) - 1000000);
		if (p == 8) return 32'h7fffffff - $urandom_range(0, 3);
		return 32'h80000000 + $urandom_range(0, 3);
	endfunction

	function automatic sample_t make_word(logic [1:0] op, logic [47:0] ts, logic [47:0] tt);
		sample_t s;
		s.op = op;
		s.ts = ts;
		s.tt = tt;
		for (int i = 0; i < 6; i++)
			s.v[i] = rand_coord();
		s.cc = 16'($urandom);
		s.dc = 16'($urandom);
		return s;
	endfunction

	// mostly store-then-interpolate runs with random content, some noise
	task automatic queue_random(int n);
		int made;
		int p, k;
		logic [47:0] te, tl, span;
		made = 0;
		while (made < n) begin
			p = $urandom_range(0, 99);
			if (p < 70) begin
				te = rand_time();
				add_word(make_word(OP_STORE, te, rand_time()));
				k = $urandom_range(1, 3);
				for (int i = 0; i < k; i++) begin
					case ($urandom_range(0, 5))
						0: span = 0;
						1: span = 48'({$urandom, $urandom});
						2: span = -48'($urandom_range(1, 5000));
						default: span = 48'($urandom_range(1, 100000));
					endcase
					tl = te + span;
					case ($urandom_range(0, 5))
						0: add_word(make_word(OP_INTERP, tl, rand_time()));
						1: add_word(make_word(OP_INTERP, tl, tl + 48'($urandom_range(0, 50))));
						2: add_word(make_word(OP_INTERP, tl, te - 48'($urandom_range(0, 50))));
						default: add_word(make_word(OP_INTERP, tl,
							te + 48'((64'(span) * $urandom_range(0, 1000)) / 1000)));
					endcase
				end
				made += k + 1;
			end else if (p < 85) begin
				add_word(make_word(OP_SINGLE, rand_time(), rand_time()));
				made++;
			end else if (p < 92) begin
				add_word(make_word(OP_INTERP, rand_time(), rand_time()));
				made++;
			end else if (p < 97) begin
				add_word(make_word(OP_STORE, rand_time(), rand_time()));
				made++;
			end else begin
				add_word(make_word(OP_NONE, rand_time(), rand_time()));
			end
		end
	endtask

	task automatic drain();
		while (sample_q.size() != 0 || in_valid || result_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [47:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ROT0 || idx == REG_ROT1 || idx == REG_ROT2)
			rot_m[idx[1:0]] = val;
		else if (idx == REG_SHX || idx == REG_SHY || idx == REG_SHZ)
			shift_m[2'(idx - REG_SHX)] = val[31:0];
		else if (idx == REG_CAL)
			cal_m = val[0];
	endtask

	task automatic load_matrix(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
			logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
		cfg_write(REG_ROT0, r0);
		cfg_write(REG_ROT1, r1);
		cfg_write(REG_ROT2, r2);
		cfg_write(REG_SHX, {16'b0, sx});
		cfg_write(REG_SHY, {16'b0, sy});
		cfg_write(REG_SHZ, {16'b0, sz});
		cfg_write(REG_CAL, 48'd1);
	endtask

	// directed words, then phases over several register settings
	initial begin
		sample_t s;
		rot_m[0] = 48'h0000_0000_4000;
		rot_m[1] = 48'h0000_4000_0000;
		rot_m[2] = 48'h4000_0000_0000;
		shift_m = '{default: '0};
		cal_m = 1'b0;
		early_ok = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		quiet = 1'b1;

		// interpolate before anything is stored
		add_word(make_word(OP_INTERP, 48'd1000, 48'd1500));
		// pass-through at field extremes
		s = make_word(OP_SINGLE, '1, '0);
		s.v = {6{32'h7fffffff}};
		s.cc = '1;
		s.dc = '0;
		add_word(s);
		s = make_word(OP_SINGLE, '0, '1);
		s.v = {6{32'h80000000}};
		s.cc = '0;
		s.dc = '1;
		add_word(s);
		add_word(make_word(OP_NONE, 48'd5, 48'd6));
		// earlier sample at one extreme, later at the other
		s = make_word(OP_STORE, 48'd1000, 48'd0);
		s.v = {6{32'h80000000}};
		s.cc = '0;
		s.dc = '1;
		add_word(s);
		s.op = OP_INTERP;
		s.v = {6{32'h7fffffff}};
		s.cc = '1;
		s.dc = '0;
		// zero gap, target before, target beyond, halfway, a quarter
		s.ts = 48'd1000; s.tt = 48'd1200; add_word(s);
		s.ts = 48'd2000; s.tt = 48'd900;  add_word(s);
		s.ts = 48'd2000; s.tt = 48'd2500; add_word(s);
		s.ts = 48'd2000; s.tt = 48'd1500; add_word(s);
		s.ts = 48'd2000; s.tt = 48'd1250; add_word(s);
		// later sample older than the earlier one
		s.ts = 48'd0;    s.tt = 48'd333;  add_word(s);
		s.ts = 48'd0;    s.tt = 48'd1000; add_word(s);
		// time near the top of the range
		s = make_word(OP_STORE, '1 - 48'd10, 48'd0);
		add_word(s);
		add_word(make_word(OP_INTERP, 48'd5, '1 - 48'd3));
		add_word(make_word(OP_INTERP, 48'd5, 48'd2));
		add_word(make_word(OP_INTERP, '1, '1 - 48'd7));
		drain();
		quiet = 1'b0;
		queue_random(250);
		drain();

		// identity, shift at its extremes
		load_matrix(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
			32'h7fffffff, 32'h80000000, 32'h0001_8000);
		queue_random(300);
		drain();

		// random matrix and shift
		load_matrix(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
			48'({$urandom, $urandom}), $urandom, $urandom, $urandom);
		quiet = 1'b1;
		queue_random(120);
		drain();
		quiet = 1'b0;
		queue_random(130);
		drain();

		// largest coefficients, saturating
		load_matrix(48'h7fff_8000_7fff, 48'h8000_8000_8000, 48'h7fff_7fff_7fff,
			32'h80000000, 32'h7fffffff, 32'h0);
		queue_random(200);
		drain();

		// transform off again
		cfg_write(REG_CAL, 48'd0);
		queue_random(200);
		drain();

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
